@@ rtl/slis_pkg.sv @@
// Package for the sorted list block: operation and status codes, and the
// compare result that the shared comparator hands to the sequencer.
// Depends on nothing.
`timescale 1ns / 1ps

package slis_pkg;

  // Field widths fixed by the item format.
  localparam int ModeW   = 2;
  localparam int ValueW  = 32;
  localparam int StatusW = 2;
  localparam int PosW    = 4;
  localparam int CountW  = 5;

  // Operation codes carried in the mode field.
  localparam logic [ModeW-1:0] MODE_INSERT = 2'd0;
  localparam logic [ModeW-1:0] MODE_SEARCH = 2'd1;
  localparam logic [ModeW-1:0] MODE_REMOVE = 2'd2;

  // Status codes carried in the result.
  localparam logic [StatusW-1:0] ST_OK   = 2'd0;
  localparam logic [StatusW-1:0] ST_MISS = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL = 2'd2;

  // Outcome of comparing a stored entry against the request key.
  typedef struct packed {
    logic lt;  // entry is below the key
    logic eq;  // entry equals the key
  } cmp_res_t;

endpackage

@@ rtl/slis_if.sv @@
// Channel interfaces of the sorted list block: request and response.
// Depends on slis_pkg for the field widths.
`timescale 1ns / 1ps

interface slis_req_if;
  logic                              valid;
  logic                              ready;
  logic [slis_pkg::ModeW-1:0]        mode;
  logic signed [slis_pkg::ValueW-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface slis_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [slis_pkg::StatusW-1:0] status;
  logic [slis_pkg::PosW-1:0]    position;
  logic [slis_pkg::CountW-1:0]  count;

  modport source (output valid, output status, output position, output count,
                  input ready);
  modport sink   (input valid, input status, input position, input count,
                  output ready);
endinterface

@@ rtl/slis_cmp.sv @@
// Shared signed comparator of the sorted list block.
// Depends on slis_pkg for the compare result type.
`timescale 1ns / 1ps

module slis_cmp (
  input  logic signed [slis_pkg::ValueW-1:0] entry,
  input  logic signed [slis_pkg::ValueW-1:0] key,
  output slis_pkg::cmp_res_t                 res
);

  // One signed less-than compare and one equality test per cycle.
  assign res.lt = (entry < key);
  assign res.eq = (entry == key);

endmodule

@@ rtl/sorted_list_insert_search_remove.sv @@
// Top level of the sorted list block: sequencer, entry memory and result register.
// Depends on slis_pkg, slis_if.sv and slis_cmp.
//
//   channel | dir | fields                      | role
//   req     | in  | mode, value                 | operation and signed key
//   rsp     | out | status, position, count     | one result per request
//
// An insert moves entries not below the key up one place from the top; a search
// or remove walks up from entry 0 to the first entry not below the key, and a
// remove then moves each later entry down one place. Insert on a full or empty
// table, or any request on an empty table, skips the walk. The walk is set by the
// entry memory, one read and one write a cycle, and the single comparator.
// Reset clears the count and the control state; entries are not cleared.
// A waiting result holds in its register while the next request is taken.
`timescale 1ns / 1ps

module sorted_list_insert_search_remove #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst,
  slis_req_if.sink          req,
  slis_rsp_if.source        rsp
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CntFull = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_FIND,
    S_SHIFT,
    S_POST
  } state_t;

  state_t                              state;
  logic [CW-1:0]                       cnt;
  logic [IW-1:0]                       ridx;
  logic [IW-1:0]                       widx;
  logic signed [slis_pkg::ValueW-1:0]  key;
  logic                                is_remove;
  logic [slis_pkg::StatusW-1:0]        res_status;
  logic [IW-1:0]                       res_pos;

  logic                                out_valid;
  logic [slis_pkg::StatusW-1:0]        out_status;
  logic [slis_pkg::PosW-1:0]           out_pos;
  logic [slis_pkg::CountW-1:0]         out_count;

  // Entry memory with registered read data.
  logic signed [slis_pkg::ValueW-1:0]  entries [CAPACITY];
  logic signed [slis_pkg::ValueW-1:0]  rdata;
  logic [IW-1:0]                       rd_addr;
  logic                                we;
  logic [IW-1:0]                       waddr;
  logic signed [slis_pkg::ValueW-1:0]  wdata;

  slis_pkg::cmp_res_t                  cmp;

  slis_cmp u_cmp (
    .entry (rdata),
    .key   (key),
    .res   (cmp)
  );

  assign req.ready    = (state == S_IDLE);
  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.position = out_pos;
  assign rsp.count    = out_count;

  // Memory port control: the read for the next step is issued ahead, since read data is registered.
  always_comb begin
    we      = 1'b0;
    waddr   = widx;
    wdata   = rdata;
    rd_addr = '0;
    case (state)
      S_IDLE: begin
        if (req.mode == slis_pkg::MODE_INSERT) begin
          rd_addr = IW'(cnt - CW'(1));
        end
        if (req.valid && req.mode == slis_pkg::MODE_INSERT && cnt == '0) begin
          we    = 1'b1;
          waddr = '0;
          wdata = req.value;
        end
      end
      S_INS: begin
        rd_addr = widx - IW'(2);
        we      = 1'b1;
        if (widx == '0 || cmp.lt) begin
          wdata = key;
        end
      end
      S_FIND: begin
        rd_addr = ridx + IW'(1);
      end
      S_SHIFT: begin
        rd_addr = widx + IW'(2);
        we      = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      entries[waddr] <= wdata;
    end
    rdata <= entries[rd_addr];
  end

  // Sequencer, count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // A taken result empties the register unless a new one is loaded below.
      if (out_valid && rsp.ready && state != S_POST) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            key       <= req.value;
            is_remove <= (req.mode == slis_pkg::MODE_REMOVE);
            res_pos   <= '0;
            case (req.mode)
              slis_pkg::MODE_INSERT: begin
                if (cnt == CntFull) begin
                  res_status <= slis_pkg::ST_FULL;
                  state      <= S_POST;
                end else if (cnt == '0) begin
                  res_status <= slis_pkg::ST_OK;
                  cnt        <= CW'(1);
                  state      <= S_POST;
                end else begin
                  res_status <= slis_pkg::ST_MISS;
                  widx       <= IW'(cnt);
                  state      <= S_INS;
                end
              end
              slis_pkg::MODE_SEARCH, slis_pkg::MODE_REMOVE: begin
                res_status <= slis_pkg::ST_MISS;
                if (cnt == '0) begin
                  state <= S_POST;
                end else begin
                  ridx  <= '0;
                  state <= S_FIND;
                end
              end
              default: begin
                res_status <= slis_pkg::ST_MISS;
                state      <= S_POST;
              end
            endcase
          end
        end
        S_INS: begin
          // Move entries that are not below the key up by one place.
          if (widx == '0 || cmp.lt) begin
            res_status <= slis_pkg::ST_OK;
            res_pos    <= widx;
            cnt        <= cnt + CW'(1);
            state      <= S_POST;
          end else begin
            widx <= widx - IW'(1);
          end
        end
        S_FIND: begin
          // Walk up to the first entry that is not below the key.
          if (cmp.lt) begin
            if (CW'(ridx) + CW'(1) == cnt) begin
              state <= S_POST;
            end else begin
              ridx <= ridx + IW'(1);
            end
          end else if (cmp.eq) begin
            res_status <= slis_pkg::ST_OK;
            res_pos    <= ridx;
            if (!is_remove) begin
              state <= S_POST;
            end else if (CW'(ridx) + CW'(1) == cnt) begin
              cnt   <= cnt - CW'(1);
              state <= S_POST;
            end else begin
              widx  <= ridx;
              state <= S_SHIFT;
            end
          end else begin
            state <= S_POST;
          end
        end
        S_SHIFT: begin
          // Close the gap left by the removed entry.
          if (CW'(widx) + CW'(2) == cnt) begin
            cnt   <= cnt - CW'(1);
            state <= S_POST;
          end else begin
            widx <= widx + IW'(1);
          end
        end
        S_POST: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_pos    <= slis_pkg::PosW'(res_pos);
            out_count  <= slis_pkg::CountW'(cnt);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/slis_check.sv @@
// Port checker of the sorted list block and the bind that attaches it.
// Depends on slis_pkg and on the top level sorted_list_insert_search_remove.
`timescale 1ns / 1ps

module slis_check #(
  parameter int CAPACITY = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [slis_pkg::StatusW-1:0] rsp_status,
  input logic [slis_pkg::PosW-1:0]    rsp_position,
  input logic [slis_pkg::CountW-1:0]  rsp_count
);

  localparam logic [slis_pkg::CountW:0] CapW = (slis_pkg::CountW + 1)'(CAPACITY);

  logic                        req_fire;
  logic                        rsp_fire;
  logic [1:0]                  pending;
  logic [slis_pkg::CountW-1:0] last_count;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  // Track items taken but not yet answered, and the last count reported.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      last_count <= '0;
    end else begin
      pending <= pending + 2'(req_fire) - 2'(rsp_fire);
      if (rsp_fire) begin
        last_count <= rsp_count;
      end
    end
  end

  // Every result answers an item that was taken.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    rsp_fire |-> pending != 2'd0)
    else $error("result delivered with no item outstanding");

  // A result that is not a success carries position zero.
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != slis_pkg::ST_OK |-> rsp_position == '0)
    else $error("nonzero position on a failed item");

  // A full status only comes with a full table.
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == slis_pkg::ST_FULL |-> {1'b0, rsp_count} == CapW)
    else $error("full status with a table that is not full");

  // The count moves by at most one from one result to the next.
  a_step: assert property (@(posedge clk) disable iff (rst)
    rsp_fire |-> (rsp_count == last_count) ||
                 (rsp_count == last_count + 5'd1) ||
                 (last_count == rsp_count + 5'd1))
    else $error("count jumped by more than one");

  // A stalled result holds its fields.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                $stable(rsp_position) && $stable(rsp_count))
    else $error("stalled result changed");

endmodule

bind sorted_list_insert_search_remove slis_check #(.CAPACITY(CAPACITY)) u_slis_check (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_status   (rsp.status),
  .rsp_position (rsp.position),
  .rsp_count    (rsp.count)
);
